[sv/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scan debounce block
// Key codes, op codes, machine states and the structs passed between modules.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int KEY_COUNT = 12;
  localparam int OP_W      = 2;
  localparam int CODE_W    = 4;
  localparam int TICK_W    = 8;

  localparam logic [TICK_W-1:0] TICK_MAX       = 8'hFF;
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd8;
  localparam logic [CODE_W-1:0] KEY_STAR       = 4'd10;
  localparam logic [CODE_W-1:0] KEY_HASH       = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_WAIT    = 2'd1,
    ST_CONFIRM = 2'd2,
    ST_RELEASE = 2'd3
  } scan_state_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } first_key_t;

  typedef struct packed {
    logic              flag;
    logic [CODE_W-1:0] key;
  } result_t;

  // Matrix position (row*3+col) to key code: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
  function automatic logic [CODE_W-1:0] key_of_pos(input logic [3:0] pos);
    logic [CODE_W-1:0] code;
    case (pos)
      4'd9:    code = KEY_STAR;
      4'd10:   code = 4'd0;
      4'd11:   code = KEY_HASH;
      default: code = pos + 4'd1;
    endcase
    return code;
  endfunction

endpackage

[sv/kpd_first_key.sv]
// ----------------------------------------------------------------------------
// kpd_first_key: row-major priority pick over the key matrix
// Reports whether any key is down and the code of the lowest pressed position.
// ----------------------------------------------------------------------------
module kpd_first_key (
  input  logic [kpd_pkg::KEY_COUNT-1:0] key_matrix,
  output kpd_pkg::first_key_t           first
);

  always_comb begin
    first.hit  = 1'b0;
    first.code = '0;
    // walk down so the lowest set position is the last to write
    for (int i = kpd_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (key_matrix[i]) begin
        first.hit  = 1'b1;
        first.code = kpd_pkg::key_of_pos(4'(i));
      end
    end
  end

endmodule

[sv/kpd_fsm.sv]
// ----------------------------------------------------------------------------
// kpd_fsm: debounce state machine and key store
// Holds scan state, pending/stored key, new-key flag and the tick counter.
// ----------------------------------------------------------------------------
module kpd_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [kpd_pkg::OP_W-1:0]     op,
  input  kpd_pkg::first_key_t          first,
  input  logic [kpd_pkg::TICK_W-1:0]   debounce_ticks,
  output kpd_pkg::result_t             result
);

  kpd_pkg::scan_state_t          scan_state, scan_state_next;
  logic [kpd_pkg::CODE_W-1:0]    pending_key, pending_key_next;
  logic [kpd_pkg::CODE_W-1:0]    stored_key, stored_key_next;
  logic                          fresh_flag, fresh_flag_next;
  logic [kpd_pkg::TICK_W-1:0]    tick_count, tick_count_next;

  logic is_tick, is_step, is_read, confirm_ok;

  always_comb begin
    is_tick = 1'b0;
    is_step = 1'b0;
    is_read = 1'b0;
    unique case (op)
      kpd_pkg::OP_TICK: is_tick = 1'b1;
      kpd_pkg::OP_STEP: is_step = 1'b1;
      kpd_pkg::OP_READ: is_read = 1'b1;
      default: ;
    endcase
  end

  assign confirm_ok = is_step && (scan_state == kpd_pkg::ST_CONFIRM) &&
                      first.hit && (first.code == pending_key);

  // next state
  always_comb begin
    scan_state_next = scan_state;
    if (is_step) begin
      unique case (scan_state)
        kpd_pkg::ST_IDLE: begin
          if (first.hit) scan_state_next = kpd_pkg::ST_WAIT;
        end
        kpd_pkg::ST_WAIT: begin
          if (tick_count >= debounce_ticks) scan_state_next = kpd_pkg::ST_CONFIRM;
        end
        kpd_pkg::ST_CONFIRM: begin
          scan_state_next = confirm_ok ? kpd_pkg::ST_RELEASE : kpd_pkg::ST_IDLE;
        end
        kpd_pkg::ST_RELEASE: begin
          if (!first.hit) scan_state_next = kpd_pkg::ST_IDLE;
        end
        default: scan_state_next = kpd_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    pending_key_next = pending_key;
    stored_key_next  = stored_key;
    fresh_flag_next  = fresh_flag;
    tick_count_next  = tick_count;
    if (is_tick && (tick_count < kpd_pkg::TICK_MAX)) begin
      tick_count_next = tick_count + 1'b1;
    end
    if (is_step && (scan_state == kpd_pkg::ST_IDLE) && first.hit) begin
      pending_key_next = first.code;
      tick_count_next  = '0;
    end
    if (confirm_ok) begin
      stored_key_next = pending_key;
      fresh_flag_next = 1'b1;
    end
    // flag reported before the read clears it
    result.flag = fresh_flag_next;
    result.key  = stored_key_next;
    if (is_read) fresh_flag_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= kpd_pkg::ST_IDLE;
      pending_key <= '0;
      stored_key  <= '0;
      fresh_flag  <= 1'b0;
      tick_count  <= '0;
    end else if (fire) begin
      scan_state  <= scan_state_next;
      pending_key <= pending_key_next;
      stored_key  <= stored_key_next;
      fresh_flag  <= fresh_flag_next;
      tick_count  <= tick_count_next;
    end
  end

endmodule

[sv/keypad_scan_debounce.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce: 4x3 keypad qualifier with debounce
// Ticks, matrix snapshots and key reads in; one flag/key word out per item.
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_stall  | op[1:0], key_matrix[11:0]
//   out      | out_valid / out_stall| new_key_flag, key_code[3:0]
//   cfg      | cfg_valid / cfg_ready| debounce_ticks[7:0]
//
// One word per cycle sustained while out_stall is low; the path runs from the input
// register to the result register, with the state machine update between them.
// The input register takes a new word while a result waits on out_stall, if it is empty;
// in_stall rises only when both stages are full and the output is stalled.
// rst is synchronous, active high: state idle, counters and flag cleared,
// debounce_ticks back to 8. cfg_ready is always high.
// ----------------------------------------------------------------------------
module keypad_scan_debounce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kpd_pkg::OP_W-1:0]          op,
  input  logic [kpd_pkg::KEY_COUNT-1:0]     key_matrix,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              new_key_flag,
  output logic [kpd_pkg::CODE_W-1:0]        key_code,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kpd_pkg::TICK_W-1:0]        debounce_ticks
);

  // debounce threshold register
  logic [kpd_pkg::TICK_W-1:0] threshold;

  // input register stage
  logic                          a_valid;
  logic [kpd_pkg::OP_W-1:0]      a_op;
  logic [kpd_pkg::KEY_COUNT-1:0] a_matrix;
  logic                          a_fire, in_take;

  kpd_pkg::first_key_t first;
  kpd_pkg::result_t    result;

  assign cfg_ready = 1'b1;
  assign a_fire    = a_valid && (!out_valid || !out_stall);
  assign in_stall  = a_valid && !a_fire;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kpd_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= debounce_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op     <= op;
      a_matrix <= key_matrix;
    end
  end

  kpd_first_key u_first (
    .key_matrix (a_matrix),
    .first      (first)
  );

  kpd_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .fire           (a_fire),
    .op             (a_op),
    .first          (first),
    .debounce_ticks (threshold),
    .result         (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      new_key_flag <= result.flag;
      key_code     <= result.key;
    end
  end

  // a word held in the input stage behind a stalled result is kept
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_valid && out_stall) |=> a_valid)
    else $error("input stage word lost under output stall");

  // every word leaving the input stage shows up as a result
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    a_fire |=> out_valid)
    else $error("processed word did not reach the result register");

  // delivered key codes stay in the keypad range
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_code <= kpd_pkg::KEY_HASH))
    else $error("key code out of range");

  // the input side stalls only while both stages are occupied
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

[dv/keypad_scan_debounce_check.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce_check: result checker for the keypad scan debounce block
// Watches the input, output and register channels, keeps its own copy of the
// keypad qualifier state and compares every output word with the oldest one due.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [kpd_pkg::OP_W-1:0]     op,
  input  logic [kpd_pkg::KEY_COUNT-1:0] key_matrix,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         new_key_flag,
  input  logic [kpd_pkg::CODE_W-1:0]   key_code,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [kpd_pkg::TICK_W-1:0]   debounce_ticks,
  output int                           fail_count,
  output int                           in_flight
);

  // Predicted state of the qualifier
  kpd_pkg::scan_state_t       mach;
  logic [kpd_pkg::CODE_W-1:0] latched_key;
  logic [kpd_pkg::CODE_W-1:0] confirmed_key;
  logic                       fresh;
  logic [kpd_pkg::TICK_W-1:0] ticks;
  logic [kpd_pkg::TICK_W-1:0] threshold;

  kpd_pkg::result_t reports_due[$];
  kpd_pkg::result_t oldest;

  // Lowest set position wins; descending loop so the lowest is written last.
  function automatic void lowest_key(input logic [kpd_pkg::KEY_COUNT-1:0] m,
                                     output logic hit,
                                     output logic [kpd_pkg::CODE_W-1:0] code);
    hit  = 1'b0;
    code = '0;
    for (int p = kpd_pkg::KEY_COUNT - 1; p >= 0; p--) begin
      if (m[p]) begin
        hit = 1'b1;
        case (p)
          9:       code = kpd_pkg::KEY_STAR;
          10:      code = '0;
          11:      code = kpd_pkg::KEY_HASH;
          default: code = kpd_pkg::CODE_W'(p + 1);
        endcase
      end
    end
  endfunction

  function automatic kpd_pkg::result_t advance_keypad(
      input logic [kpd_pkg::OP_W-1:0]      word_op,
      input logic [kpd_pkg::KEY_COUNT-1:0] m);
    logic                       hit;
    logic [kpd_pkg::CODE_W-1:0] code;
    kpd_pkg::result_t           rep;
    lowest_key(m, hit, code);
    if (word_op == kpd_pkg::OP_TICK) begin
      if (ticks != kpd_pkg::TICK_MAX) ticks = ticks + 1'b1;
    end else if (word_op == kpd_pkg::OP_STEP) begin
      case (mach)
        kpd_pkg::ST_IDLE: begin
          if (hit) begin
            latched_key = code;
            ticks       = '0;
            mach        = kpd_pkg::ST_WAIT;
          end
        end
        kpd_pkg::ST_WAIT: begin
          if (ticks >= threshold) mach = kpd_pkg::ST_CONFIRM;
        end
        kpd_pkg::ST_CONFIRM: begin
          if (hit && code == latched_key) begin
            confirmed_key = latched_key;
            fresh         = 1'b1;
            mach          = kpd_pkg::ST_RELEASE;
          end else begin
            mach = kpd_pkg::ST_IDLE;
          end
        end
        default: begin
          if (!hit) mach = kpd_pkg::ST_IDLE;
        end
      endcase
    end
    rep.flag = fresh;
    rep.key  = confirmed_key;
    if (word_op == kpd_pkg::OP_READ) fresh = 1'b0;
    return rep;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      mach          = kpd_pkg::ST_IDLE;
      latched_key   = '0;
      confirmed_key = '0;
      fresh         = 1'b0;
      ticks         = '0;
      threshold     = kpd_pkg::DEBOUNCE_RESET;
      reports_due.delete();
      in_flight <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result word with none due, flag=%0b key=%0d",
                   $time, new_key_flag, key_code);
          fail_count++;
        end else begin
          oldest = reports_due.pop_front();
          if (oldest.flag !== new_key_flag) begin
            $display("%0t: new_key_flag expected %0b, got %0b",
                     $time, oldest.flag, new_key_flag);
            fail_count++;
          end
          if (oldest.key !== key_code) begin
            $display("%0t: key_code expected %0d, got %0d", $time, oldest.key, key_code);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) threshold = debounce_ticks;
      if (in_valid && !in_stall) reports_due.push_back(advance_keypad(op, key_matrix));
      in_flight <= reports_due.size();
    end
  end

endmodule

[dv/keypad_scan_debounce_test.sv]
// ----------------------------------------------------------------------------
// keypad_scan_debounce_test: top-level bench for the keypad scan debounce block
// Drives ticks, matrix snapshots and reads through several debounce settings,
// with random gaps and stalls; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_test;

  localparam int IDLE_LIMIT   = 2000; // cycles with no word moving on any channel
  localparam int HOLD_CYCLES  = 200;  // the one long receiver hold-off
  localparam int DRAIN_CYCLES = 6;    // margin after the in-flight count reaches zero
  localparam int PHASE_WORDS  = 190;
  localparam logic [kpd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          in_valid   = 1'b0;
  logic [kpd_pkg::OP_W-1:0]      op         = kpd_pkg::OP_TICK;
  logic [kpd_pkg::KEY_COUNT-1:0] key_matrix = '0;
  logic                          out_stall  = 1'b0;
  logic                          cfg_valid  = 1'b0;
  logic [kpd_pkg::TICK_W-1:0]    debounce_ticks = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          new_key_flag;
  logic [kpd_pkg::CODE_W-1:0]    key_code;
  logic                          cfg_ready;

  int fail_count;
  int in_flight;
  int words_sent     = 0;
  int reports_seen   = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;

  logic                       squeeze_req  = 1'b0; // set by stimulus, served by the receiver
  logic                       squeeze_done = 1'b0;
  logic [kpd_pkg::TICK_W-1:0] cur_ticks    = kpd_pkg::DEBOUNCE_RESET;
  logic [kpd_pkg::TICK_W-1:0] sweep [7];

  keypad_scan_debounce dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .key_matrix     (key_matrix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_key_flag   (new_key_flag),
    .key_code       (key_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .debounce_ticks (debounce_ticks)
  );

  keypad_scan_debounce_check chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .key_matrix     (key_matrix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_key_flag   (new_key_flag),
    .key_code       (key_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .debounce_ticks (debounce_ticks),
    .fail_count     (fail_count),
    .in_flight      (in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, often a short pause, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random matrix, any keys
  function automatic logic [kpd_pkg::KEY_COUNT-1:0] rand_matrix();
    return kpd_pkg::KEY_COUNT'($urandom);
  endfunction

  // Matrix whose lowest pressed key is at pos, random presses above it
  function automatic logic [kpd_pkg::KEY_COUNT-1:0] with_lowest(input int pos);
    logic [kpd_pkg::KEY_COUNT-1:0] low;
    logic [kpd_pkg::KEY_COUNT-1:0] noise;
    low      = '0;
    low[pos] = 1'b1;
    noise    = rand_matrix();
    return (noise & ~(low - 1'b1)) | low;
  endfunction

  // Offer one word and hold it until accepted. Called and returns on a rising edge.
  task automatic send_word(input logic [kpd_pkg::OP_W-1:0] w_op,
                           input logic [kpd_pkg::KEY_COUNT-1:0] w_m);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= w_op;
    key_matrix <= w_m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Register write only once the block has drained
  task automatic write_threshold(input logic [kpd_pkg::TICK_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    debounce_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_ticks = v;
    settings_used++;
  endtask

  // One press: first press, debounce ticks, step into confirm, rescan,
  // then held keys and reads until release. Now and then cut short or broken.
  task automatic run_press();
    int                            p;
    int                            n;
    int                            r;
    logic [kpd_pkg::KEY_COUNT-1:0] m;
    p = $urandom_range(0, kpd_pkg::KEY_COUNT - 1);
    send_word(kpd_pkg::OP_STEP, with_lowest(p));
    if ($urandom_range(0, 4) != 0) n = int'(cur_ticks) + $urandom_range(0, 2);
    else n = $urandom_range(0, int'(cur_ticks));
    // top setting: run the counter well into saturation
    if (cur_ticks == kpd_pkg::TICK_MAX) n = 300;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 17) send_word(kpd_pkg::OP_TICK, rand_matrix());
      else if (r < 19) send_word(kpd_pkg::OP_READ, rand_matrix());
      else send_word(kpd_pkg::OP_STEP, rand_matrix());
    end
    send_word(kpd_pkg::OP_STEP, rand_matrix());
    r = $urandom_range(0, 19);
    if (r < 15) m = with_lowest(p);
    else if (r < 18) m = '0;
    else m = rand_matrix();
    send_word(kpd_pkg::OP_STEP, m);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) send_word(kpd_pkg::OP_READ, rand_matrix());
      else send_word(kpd_pkg::OP_STEP, with_lowest($urandom_range(0, kpd_pkg::KEY_COUNT - 1)));
    end
    if ($urandom_range(0, 4) != 0) send_word(kpd_pkg::OP_READ, rand_matrix());
    send_word(kpd_pkg::OP_STEP, '0);
  endtask

  // Unstructured words, the unused op among them
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, rand_matrix());
      else send_word(kpd_pkg::OP_W'($urandom_range(0, 2)), rand_matrix());
    end
  endtask

  // Stimulus
  initial begin
    int start;
    sweep[0] = 8'd1;
    sweep[1] = 8'd4;
    sweep[2] = kpd_pkg::TICK_MAX;
    sweep[3] = 8'd0;
    sweep[4] = 8'd2;
    sweep[5] = kpd_pkg::TICK_W'($urandom_range(1, 12));
    sweep[6] = kpd_pkg::DEBOUNCE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset setting of 8: a full press of hash
    send_word(kpd_pkg::OP_READ, '0);
    send_word(OP_UNUSED, '1);                // unused op leaves state alone
    send_word(kpd_pkg::OP_TICK, '1);
    send_word(kpd_pkg::OP_STEP, '0);         // idle, nothing pressed
    send_word(kpd_pkg::OP_STEP, 12'h800);    // hash latched, counter cleared
    send_word(kpd_pkg::OP_STEP, 12'h800);    // still short of the threshold
    repeat (8) send_word(kpd_pkg::OP_TICK, '0);
    send_word(kpd_pkg::OP_STEP, 12'h800);    // threshold met, into confirm
    send_word(kpd_pkg::OP_STEP, 12'h800);    // rescan agrees: hash stored, flag up
    send_word(OP_UNUSED, '0);
    send_word(kpd_pkg::OP_STEP, 12'h201);    // keys still down, wait for release
    send_word(kpd_pkg::OP_READ, '0);         // flag seen then cleared
    send_word(kpd_pkg::OP_READ, '0);
    send_word(kpd_pkg::OP_STEP, '0);         // released, back to idle

    // Zero threshold: wait passes on the first step; both ways confirm fails
    write_threshold('0);
    send_word(kpd_pkg::OP_STEP, 12'hE00);    // several keys, star wins
    send_word(kpd_pkg::OP_STEP, '0);
    send_word(kpd_pkg::OP_STEP, 12'h400);    // different key in confirm
    send_word(kpd_pkg::OP_STEP, 12'h400);
    send_word(kpd_pkg::OP_STEP, '0);
    send_word(kpd_pkg::OP_STEP, '0);         // nothing pressed in confirm

    // Random phases over the setting sweep
    for (int i = 0; i < 7; i++) begin
      write_threshold(sweep[i]);
      if (i == 1) squeeze_req <= 1'b1;
      if (sweep[i] == kpd_pkg::TICK_MAX) begin
        run_press();
      end else begin
        start = words_sent;
        while (words_sent - start < PHASE_WORDS) begin
          if ($urandom_range(0, 6) != 0) run_press();
          else run_noise();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words and took %0d results over %0d debounce settings,",
             words_sent, reports_seen, settings_used);
    $display("including one %0d-cycle output hold-off with the input backed up.",
             HOLD_CYCLES);
    if (fail_count == 0 && in_flight == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: random stall stretches, calm runs, and the one long hold-off
  initial begin
    int hold;
    int pass_len;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold         = HOLD_CYCLES;
      end else begin
        hold = gap_len();
      end
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 15) == 0) pass_len = $urandom_range(30, 80);
      else pass_len = $urandom_range(1, 6);
      repeat (pass_len) @(posedge clk);
    end
  end

  // Watchdog: ends the run once no word has moved for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) reports_seen++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timed out after %0d cycles with no word moving", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
sv/kpd_pkg.sv
sv/kpd_first_key.sv
sv/kpd_fsm.sv
sv/keypad_scan_debounce.sv
dv/keypad_scan_debounce_check.sv
dv/keypad_scan_debounce_test.sv
